// File: hdl/lks_pkg.sv
// Shared constants for the LRU key set.
`default_nettype none

package lks_pkg;

  // Geometry of the set
  localparam int ENTRIES  = 16;
  localparam int KEY_BITS = 32;

  // Fixed field widths of the request and the capacity register
  localparam int KIND_W = 2;
  localparam int KEY_W  = 32;
  localparam int CAP_W  = 5;

  // Derived widths
  localparam int STORE_W = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W  = IDX_W;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

endpackage

`default_nettype wire

// File: hdl/lru_key_set_top.sv
// LRU key set: fully associative key store with recency ranks and bounded capacity.
//
// Fully associative set of up to lks_pkg::ENTRIES keys kept in least-recently-used
// order. Each request transfer carries a kind (lookup, insert, clear) and a key and
// yields exactly one result transfer with hit = 1 when the key was already present.
// A hit (lookup or insert) promotes the key to most recent; an insert of a new key
// places it as most recent and, when the count is already at the capacity, drops the
// least recent key first. Clear empties the set; kind 3 leaves it unchanged (hit 0).
// The capacity register is clamped to 1..ENTRIES; lowering it below the current
// count evicts only one key per later insert. Write it only while the block is idle.
// Rate: one request per clock while the result side does not stall. A request is
// captured in an input register, then the parallel key compare, rank update and
// victim/free-slot pick resolve combinationally into the state and the result
// register. Back-pressure on the result side reaches in_stall_o in the same cycle;
// the input register keeps one request while the result register holds a finished
// one.
`default_nettype none

module lru_key_set_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration: capacity register
  input  wire logic                           cfg_we_i,
  input  wire logic [lks_pkg::CAP_W-1:0]      cfg_wdata_i,
  // request channel
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire logic [lks_pkg::KIND_W-1:0]     kind_i,
  input  wire logic [lks_pkg::KEY_W-1:0]      key_i,
  // result channel
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      logic                           hit_o
);

  localparam int N = lks_pkg::ENTRIES;

  // capacity register
  logic [lks_pkg::CAP_W-1:0] cap_q;

  // request register
  logic                           req_valid_q;
  logic [lks_pkg::KIND_W-1:0]     kind_q;
  logic [lks_pkg::STORE_W-1:0]    key_q;

  // result register
  logic out_valid_q;
  logic hit_q, hit_d;

  // set state
  logic [N-1:0]                   valid_q, valid_d;
  logic [lks_pkg::RANK_W-1:0]     rank_q [N];
  logic [lks_pkg::RANK_W-1:0]     rank_d [N];
  logic [lks_pkg::CNT_W-1:0]      count_q, count_d;
  logic [lks_pkg::STORE_W-1:0]    store_q [N];

  // store write port
  logic                           wr_en;
  logic [lks_pkg::IDX_W-1:0]      wr_idx;

  // handshake
  logic advance;   // request in the input register resolves this cycle
  logic load_req;  // input register takes a new transfer slot

  assign advance    = req_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = req_valid_q && !advance;
  assign load_req   = !in_stall_o;

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;

  // ---------------------------------------------------------------------------
  // Capacity register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lks_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (load_req) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_req && in_valid_i) begin
      kind_q <= kind_i;
      key_q  <= key_i[lks_pkg::STORE_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Next-state logic
  // ---------------------------------------------------------------------------
  logic [lks_pkg::CMP_W-1:0] cap_eff;
  logic                      full;
  logic [lks_pkg::RANK_W-1:0] lru_rank;

  always_comb begin
    // clamp capacity to 1..ENTRIES
    if (cap_q == '0) begin
      cap_eff = lks_pkg::CMP_W'(1);
    end else if (lks_pkg::CMP_W'(cap_q) > lks_pkg::CMP_W'(N)) begin
      cap_eff = lks_pkg::CMP_W'(N);
    end else begin
      cap_eff = lks_pkg::CMP_W'(cap_q);
    end
    full     = lks_pkg::CMP_W'(count_q) >= cap_eff;
    // ranks form 0..count-1, so the least recent has rank count-1
    lru_rank = lks_pkg::RANK_W'(count_q - lks_pkg::CNT_W'(1));
  end

  logic [N-1:0]               match;
  logic                       hit_any;
  logic [lks_pkg::RANK_W-1:0] hit_rank;
  logic [N-1:0]               victim;
  logic [N-1:0]               keep;
  logic [N-1:0]               free_oh;
  logic [lks_pkg::IDX_W-1:0]  free_idx;
  logic                       free_found;

  always_comb begin
    hit_any  = 1'b0;
    hit_rank = '0;
    for (int i = 0; i < N; i++) begin
      match[i]  = valid_q[i] && (store_q[i] == key_q);
      victim[i] = full && valid_q[i] && (rank_q[i] == lru_rank);
      hit_any   = hit_any | match[i];
      hit_rank  = hit_rank | (match[i] ? rank_q[i] : '0);
    end
    keep = valid_q & ~victim;

    // first free slot after the optional eviction
    free_oh    = '0;
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (!keep[i] && !free_found) begin
        free_found = 1'b1;
        free_oh[i] = 1'b1;
        free_idx   = lks_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    count_d = count_q;
    hit_d   = 1'b0;
    wr_en   = 1'b0;
    wr_idx  = free_idx;

    case (kind_q)
      lks_pkg::KIND_LOOKUP, lks_pkg::KIND_INSERT: begin
        if (hit_any) begin
          // promote: entries more recent than the hit age by one
          hit_d = 1'b1;
          for (int i = 0; i < N; i++) begin
            if (match[i]) begin
              rank_d[i] = '0;
            end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
              rank_d[i] = rank_q[i] + lks_pkg::RANK_W'(1);
            end
          end
        end else if (kind_q == lks_pkg::KIND_INSERT) begin
          for (int i = 0; i < N; i++) begin
            if (free_oh[i]) begin
              rank_d[i] = '0;
            end else if (keep[i]) begin
              rank_d[i] = rank_q[i] + lks_pkg::RANK_W'(1);
            end
          end
          valid_d = keep | free_oh;
          wr_en   = free_found;
          count_d = full ? count_q : count_q + lks_pkg::CNT_W'(1);
        end
      end
      lks_pkg::KIND_CLEAR: begin
        valid_d = '0;
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // State and result registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < N; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      if (advance) begin
        valid_q <= valid_d;
        count_q <= count_d;
        rank_q  <= rank_d;
      end
      if (!out_valid_q || !out_stall_i) begin
        out_valid_q <= advance;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      hit_q <= hit_d;
    end
    if (advance && wr_en) begin
      store_q[wr_idx] <= key_q;
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the LRU key set: random and directed transfers vs. a recency model.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD   = 120;
  // kind 3 is not decoded by the block; it must read as a miss and leave the set alone
  localparam logic [lks_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [lks_pkg::KEY_W-1:0]  KEY_MASK    =
    {lks_pkg::KEY_W{1'b1}} >> (lks_pkg::KEY_W - lks_pkg::STORE_W);

  typedef struct {
    logic [lks_pkg::KIND_W-1:0] kind;
    logic [lks_pkg::KEY_W-1:0]  key;
  } req_t;

  // ---------------------------------------------------------------------------
  // DUT signals, all driven to known values from time zero
  // ---------------------------------------------------------------------------
  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_we_i    = 1'b0;
  logic [lks_pkg::CAP_W-1:0]  cfg_wdata_i = '0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  logic [lks_pkg::KIND_W-1:0] kind_i      = lks_pkg::KIND_LOOKUP;
  logic [lks_pkg::KEY_W-1:0]  key_i       = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic                       hit_o;

  lru_key_set_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .key_i      (key_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .hit_o      (hit_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Recency model: its own copy of the set, updated once per accepted request
  // ---------------------------------------------------------------------------
  logic [lks_pkg::KEY_W-1:0] set_key  [lks_pkg::ENTRIES];
  bit                        set_vld  [lks_pkg::ENTRIES];
  int unsigned               set_rank [lks_pkg::ENTRIES];   // 0 = most recent
  int unsigned               set_cnt  = 0;
  int unsigned               cap_reg  = lks_pkg::CAP_RESET;

  // Applies one request to the model and returns the hit bit the block must report.
  function automatic bit lru_apply(logic [lks_pkg::KIND_W-1:0] kind,
                                   logic [lks_pkg::KEY_W-1:0] key_raw);
    logic [lks_pkg::KEY_W-1:0] k;
    int slot, victim, free_slot;
    int unsigned r, eff;
    k = key_raw & KEY_MASK;
    slot = -1;
    victim = -1;
    free_slot = -1;
    if (kind == lks_pkg::KIND_CLEAR) begin
      foreach (set_vld[i]) begin
        set_vld[i]  = 1'b0;
        set_rank[i] = 0;
      end
      set_cnt = 0;
      return 1'b0;
    end
    if (kind != lks_pkg::KIND_LOOKUP && kind != lks_pkg::KIND_INSERT) return 1'b0;
    foreach (set_vld[i])
      if (slot < 0 && set_vld[i] && set_key[i] == k) slot = i;
    if (slot >= 0) begin
      // hit: everything newer than the key ages by one, key becomes newest
      r = set_rank[slot];
      foreach (set_vld[i])
        if (set_vld[i] && set_rank[i] < r) set_rank[i]++;
      set_rank[slot] = 0;
      return 1'b1;
    end
    if (kind == lks_pkg::KIND_LOOKUP) return 1'b0;
    // new key: clamp capacity, drop the single oldest entry when full
    eff = (cap_reg < 1) ? 1 : (cap_reg > lks_pkg::ENTRIES) ? lks_pkg::ENTRIES : cap_reg;
    if (set_cnt >= eff) begin
      foreach (set_vld[i])
        if (set_vld[i] && (victim < 0 || set_rank[i] > set_rank[victim])) victim = i;
      if (victim >= 0) begin
        set_vld[victim]  = 1'b0;
        set_rank[victim] = 0;
        if (set_cnt > 0) set_cnt--;
      end
    end
    foreach (set_vld[i])
      if (free_slot < 0 && !set_vld[i]) free_slot = i;
    if (free_slot < 0) return 1'b0;
    foreach (set_vld[i])
      if (set_vld[i]) set_rank[i]++;
    set_vld[free_slot]  = 1'b1;
    set_key[free_slot]  = k;
    set_rank[free_slot] = 0;
    set_cnt++;
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared bookkeeping
  // ---------------------------------------------------------------------------
  req_t        pending_q[$];   // requests waiting for the driver
  bit          hit_q[$];       // predicted hit bits, oldest first
  bit          req_fire   = 1'b0;
  int unsigned error_cnt  = 0;
  int unsigned cycle_cnt  = 0;
  bit          hold_req   = 1'b0;   // toggled by the sequencer to ask for a long hold
  bit          hold_ack   = 1'b0;

  // ---------------------------------------------------------------------------
  // Rising edge: sample handshakes, predict on request transfers, check results.
  // Blocking reads here see pre-edge values; the DUT updates in the NBA region.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    req_fire <= in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (cfg_we_i) cap_reg = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) hit_q.push_back(lru_apply(kind_i, key_i));
      if (out_valid_o && !out_stall_i) begin
        if (hit_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected, hit=%b", $time, hit_o);
          error_cnt++;
        end else begin
          if (hit_o !== hit_q[0]) begin
            $display("%0t: hit mismatch, expected %b, actual %b", $time, hit_q[0], hit_o);
            error_cnt++;
          end
          void'(hit_q.pop_front());
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver: falling edge, payload held while stalled. After each
  // transfer it may insert a gap; a quiet mode gives back-to-back stretches.
  // ---------------------------------------------------------------------------
  int unsigned gap_left = 0;
  bit          tx_quiet = 1'b0;
  int unsigned tx_roll;
  req_t        tx_req;

  always @(negedge clk_i) begin
    if (!in_valid_i || req_fire) begin
      if ($urandom_range(0, 63) == 0) tx_quiet = !tx_quiet;
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left--;
      end else if (pending_q.size() > 0) begin
        tx_req = pending_q.pop_front();
        in_valid_i <= 1'b1;
        kind_i     <= tx_req.kind;
        key_i      <= tx_req.key;
        tx_roll = $urandom_range(0, 99);
        if (tx_quiet || tx_roll < 60) gap_left = 0;
        else if (tx_roll < 92)        gap_left = $urandom_range(1, 3);
        else                          gap_left = $urandom_range(8, 30);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stall runs, plus a long hold on request from the
  // sequencer so the block backs up and stalls its request side.
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;
  bit          rx_quiet   = 1'b0;
  int unsigned rx_roll;

  always @(negedge clk_i) begin
    if ($urandom_range(0, 63) == 0) rx_quiet = !rx_quiet;
    if (hold_req != hold_ack) begin
      hold_ack   = hold_req;
      stall_left = LONG_HOLD;
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_quiet || rx_roll < 70) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b1;
        stall_left = (rx_roll < 92) ? $urandom_range(0, 2) : $urandom_range(7, 29);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  task automatic push_req(logic [lks_pkg::KIND_W-1:0] kind, logic [lks_pkg::KEY_W-1:0] key);
    req_t r;
    r.kind = kind;
    r.key  = key;
    pending_q.push_back(r);
  endtask

  // Sender holds back until every predicted result has been checked.
  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid_i || hit_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Capacity writes only happen with the block drained.
  task automatic write_capacity(int unsigned cap);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lks_pkg::CAP_W'(cap);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Random requests over a small key pool so hits and evictions are common;
  // a few keys are fresh random values and the pool may carry all-zero/all-one keys.
  task automatic random_phase(int unsigned n, int unsigned pool_n);
    logic [lks_pkg::KEY_W-1:0] pool[$];
    logic [lks_pkg::KEY_W-1:0] k;
    logic [lks_pkg::KIND_W-1:0] kind;
    int unsigned roll;
    for (int i = 0; i < pool_n; i++) begin
      roll = $urandom_range(0, 19);
      pool.push_back(roll == 0 ? '0 : roll == 1 ? '1 : lks_pkg::KEY_W'($urandom));
    end
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45)      kind = lks_pkg::KIND_INSERT;
      else if (roll < 95) kind = lks_pkg::KIND_LOOKUP;
      else if (roll < 97) kind = lks_pkg::KIND_CLEAR;
      else                kind = KIND_UNUSED;
      k = ($urandom_range(0, 9) == 0) ? lks_pkg::KEY_W'($urandom)
                                      : pool[$urandom_range(0, pool_n - 1)];
      push_req(kind, k);
    end
  endtask

  // capacity, length, key pool size, long receiver hold per random phase;
  // the 31 phase overfills and the 3 phase that follows lowers capacity below the count
  int unsigned ph_cap  [10] = '{31, 3, 16, 1, 0, 8, 17, 5, 2, 12};
  int unsigned ph_len  [10] = '{120, 100, 120, 80, 60, 100, 100, 100, 80, 120};
  int unsigned ph_pool [10] = '{22, 8, 20, 4, 3, 12, 24, 10, 5, 16};
  bit          ph_hold [10] = '{0, 0, 1, 0, 0, 0, 0, 1, 0, 0};

  initial begin
    foreach (set_vld[i]) begin
      set_key[i]  = '0;
      set_vld[i]  = 1'b0;
      set_rank[i] = 0;
    end

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed, reset capacity: empty lookup, key extremes, re-insert hit,
    // unused kind, clear, then lookups after the clear.
    push_req(lks_pkg::KIND_LOOKUP, '0);
    push_req(lks_pkg::KIND_INSERT, '0);
    push_req(lks_pkg::KIND_INSERT, '1);
    push_req(lks_pkg::KIND_LOOKUP, '0);
    push_req(lks_pkg::KIND_LOOKUP, '1);
    push_req(lks_pkg::KIND_INSERT, '1);
    push_req(KIND_UNUSED, 32'h1234_5678);
    push_req(lks_pkg::KIND_LOOKUP, '0);
    push_req(lks_pkg::KIND_CLEAR,  '1);
    push_req(lks_pkg::KIND_LOOKUP, '0);
    push_req(lks_pkg::KIND_INSERT, 32'hAAAA_AAAA);
    push_req(lks_pkg::KIND_INSERT, 32'h5555_5555);
    push_req(lks_pkg::KIND_LOOKUP, 32'h5555_5555);
    wait_drained();

    // Directed, capacity zero behaves as one: second insert evicts the first.
    write_capacity(0);
    push_req(lks_pkg::KIND_INSERT, 32'h0000_0001);
    push_req(lks_pkg::KIND_INSERT, 32'h8000_0000);
    push_req(lks_pkg::KIND_LOOKUP, 32'h0000_0001);
    push_req(lks_pkg::KIND_LOOKUP, 32'h8000_0000);
    push_req(lks_pkg::KIND_LOOKUP, 32'h0000_0003);
    wait_drained();

    for (int p = 0; p < 10; p++) begin
      write_capacity(ph_cap[p]);
      if (ph_hold[p]) hold_req = !hold_req;
      random_phase(ph_len[p], ph_pool[p]);
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/lks_pkg.sv
hdl/lru_key_set_top.sv
tb/sv/tb_top.sv
